FILE: rtl/tlsas_pkg.sv
// ----------------------------------------------------------------------------
// tlsas_pkg: shared types and constants
// Field widths, form selector codes and the control structs passed between
// the sequencer, the address unit and the top level.
// ----------------------------------------------------------------------------
package tlsas_pkg;

  localparam int FUNC_W  = 3;
  localparam int INSTR_W = 16;
  localparam int WORD_W  = 32;
  localparam int REG_W   = 3;
  localparam int LIST_W  = 8;

  // Form selector codes; anything else is unsupported.
  localparam logic [FUNC_W-1:0] FN_LDR_IMM  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_STR_IMM  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_STRH_IMM = 3'd3;
  localparam logic [FUNC_W-1:0] FN_LDR_PC   = 3'd4;
  localparam logic [FUNC_W-1:0] FN_STMIA    = 3'd5;
  localparam logic [FUNC_W-1:0] FN_LDMIA    = 3'd6;

  localparam logic [WORD_W-1:0] WORD_STEP = 32'd4;

  // Control of the shared adder.
  typedef struct packed {
    logic load;      // take new operands
    logic step;      // accumulator <= sum
    logic add_off;   // add the instruction offset
    logic add_word;  // add one word
  } agu_ctl_t;

  // One result as decided by the sequencer.
  typedef struct packed {
    logic             fire;
    logic             access;
    logic             is_write;
    logic             is_half;
    logic             addr_sum;   // address is the aligned sum, else accumulator
    logic [REG_W-1:0] reg_index;
    logic             wb_valid;
    logic [REG_W-1:0] wb_reg;
    logic             last;
    logic             unimp;
  } seq_res_t;

  // Byte offset that an instruction adds to its base.
  function automatic logic [WORD_W-1:0] offset_of(logic [FUNC_W-1:0]  fn,
                                                  logic [INSTR_W-1:0] ins);
    logic [WORD_W-1:0] off;
    off = '0;
    case (fn)
      FN_LDR_IMM, FN_STR_IMM: begin
        off = {25'd0, ins[10:6], 2'b00};
      end
      FN_STRH_IMM: begin
        off = {26'd0, ins[10:6], 1'b0};
      end
      FN_LDR_PC: begin
        off = {22'd0, ins[7:0], 2'b00};
      end
      default: begin
        off = '0;
      end
    endcase
    return off;
  endfunction

endpackage

FILE: rtl/tlsas_if.sv
// ----------------------------------------------------------------------------
// tlsas channel interfaces
// Valid/ready channels for instruction requests and access results.
// ----------------------------------------------------------------------------
interface tlsas_in_if;
  logic                                valid;
  logic                                ready;
  logic [tlsas_pkg::FUNC_W-1:0]        func;
  logic [tlsas_pkg::INSTR_W-1:0]       instr;
  logic [tlsas_pkg::WORD_W-1:0]        base_value;
  logic [tlsas_pkg::WORD_W-1:0]        pc_value;

  modport source (output valid, func, instr, base_value, pc_value, input ready);
  modport sink   (input valid, func, instr, base_value, pc_value, output ready);
endinterface

interface tlsas_out_if;
  logic                                valid;
  logic                                ready;
  logic                                access_valid;
  logic                                is_write;
  logic                                is_halfword;
  logic [tlsas_pkg::WORD_W-1:0]        address;
  logic [tlsas_pkg::REG_W-1:0]         reg_index;
  logic                                writeback_valid;
  logic [tlsas_pkg::REG_W-1:0]         writeback_reg;
  logic [tlsas_pkg::WORD_W-1:0]        writeback_value;
  logic                                last;
  logic                                unimplemented;

  modport source (output valid, access_valid, is_write, is_halfword, address, reg_index,
                  writeback_valid, writeback_reg, writeback_value, last, unimplemented,
                  input ready);
  modport sink   (input valid, access_valid, is_write, is_halfword, address, reg_index,
                  writeback_valid, writeback_reg, writeback_value, last, unimplemented,
                  output ready);
endinterface

FILE: rtl/tlsas_agu.sv
// ----------------------------------------------------------------------------
// tlsas_agu: shared address adder
// One 32-bit accumulator and one adder; adds the offset, one word or nothing.
// ----------------------------------------------------------------------------
module tlsas_agu (
  input  logic                          clk,
  input  tlsas_pkg::agu_ctl_t           ctl,
  input  logic [tlsas_pkg::WORD_W-1:0]  init_a,
  input  logic [tlsas_pkg::WORD_W-1:0]  offset,
  output logic [tlsas_pkg::WORD_W-1:0]  acc,
  output logic [tlsas_pkg::WORD_W-1:0]  sum
);

  logic [tlsas_pkg::WORD_W-1:0] acc_r;
  logic [tlsas_pkg::WORD_W-1:0] off_r;
  logic [tlsas_pkg::WORD_W-1:0] op_b;

  always_comb begin
    if (ctl.add_off) begin
      op_b = off_r;
    end else if (ctl.add_word) begin
      op_b = tlsas_pkg::WORD_STEP;
    end else begin
      op_b = '0;
    end
  end

  assign sum = acc_r + op_b;
  assign acc = acc_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      acc_r <= init_a;
      off_r <= offset;
    end else if (ctl.step) begin
      acc_r <= sum;
    end
  end

endmodule

FILE: rtl/tlsas_seq.sv
// ----------------------------------------------------------------------------
// tlsas_seq: access sequencer
// Holds one instruction and issues one result per step; walks the list.
// ----------------------------------------------------------------------------
module tlsas_seq (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_fire,
  input  logic [tlsas_pkg::FUNC_W-1:0]   func,
  input  logic [tlsas_pkg::INSTR_W-1:0]  instr,
  input  logic                           out_free,
  output logic                           in_ready,
  output tlsas_pkg::agu_ctl_t            agu_ctl,
  output tlsas_pkg::seq_res_t            res
);

  logic                           busy_r,  busy_nxt;
  logic [tlsas_pkg::FUNC_W-1:0]   sel_r;
  logic [tlsas_pkg::LIST_W-1:0]   rem_r,   rem_nxt;
  logic [tlsas_pkg::REG_W-1:0]    reg_r;
  logic [tlsas_pkg::REG_W-1:0]    rb_r;
  logic                           wbok_r;
  logic                           step;
  logic                           multi;
  logic                           single;
  logic [tlsas_pkg::REG_W-1:0]    low_idx;
  logic [tlsas_pkg::LIST_W-1:0]   rem_scan;
  logic [tlsas_pkg::REG_W-1:0]    in_rb;

  assign in_ready = !busy_r;
  assign step     = busy_r && out_free;
  assign in_rb    = instr[10:8];

  assign multi  = (sel_r == tlsas_pkg::FN_STMIA) || (sel_r == tlsas_pkg::FN_LDMIA);
  assign single = (sel_r == tlsas_pkg::FN_LDR_IMM) || (sel_r == tlsas_pkg::FN_STR_IMM) ||
                  (sel_r == tlsas_pkg::FN_STRH_IMM) || (sel_r == tlsas_pkg::FN_LDR_PC);

  // lowest pending register
  always_comb begin
    low_idx = '0;
    for (int i = tlsas_pkg::LIST_W - 1; i >= 0; i--) begin
      if (rem_r[i]) begin
        low_idx = tlsas_pkg::REG_W'(i);
      end
    end
  end

  assign rem_scan = rem_r & (rem_r - tlsas_pkg::LIST_W'(1));

  always_comb begin
    res              = '0;
    agu_ctl          = '0;
    agu_ctl.load     = in_fire;
    agu_ctl.step     = step;
    res.fire         = step;
    rem_nxt          = rem_r;
    if (multi) begin
      res.access       = (rem_r != '0);
      // empty list carries no access, so no direction either
      res.is_write     = res.access && (sel_r == tlsas_pkg::FN_STMIA);
      res.reg_index    = res.access ? low_idx : '0;
      res.last         = (rem_scan == '0);
      res.wb_valid     = res.last && wbok_r;
      res.wb_reg       = res.wb_valid ? rb_r : '0;
      agu_ctl.add_word = res.access;
      rem_nxt          = rem_scan;
    end else if (single) begin
      res.access      = 1'b1;
      res.is_write    = (sel_r == tlsas_pkg::FN_STR_IMM) || (sel_r == tlsas_pkg::FN_STRH_IMM);
      res.is_half     = (sel_r == tlsas_pkg::FN_STRH_IMM);
      res.addr_sum    = 1'b1;
      res.reg_index   = reg_r;
      res.last        = 1'b1;
      agu_ctl.add_off = 1'b1;
    end else begin
      res.unimp = 1'b1;
      res.last  = 1'b1;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    if (in_fire) begin
      busy_nxt = 1'b1;
    end else if (step && res.last) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      sel_r  <= func;
      rem_r  <= instr[tlsas_pkg::LIST_W-1:0];
      rb_r   <= in_rb;
      reg_r  <= (func == tlsas_pkg::FN_LDR_PC) ? in_rb : instr[2:0];
      wbok_r <= !((func == tlsas_pkg::FN_LDMIA) && instr[in_rb]);
    end else if (step) begin
      rem_r  <= rem_nxt;
    end
  end

endmodule

FILE: rtl/thumb_load_store_address_sequencer.sv
// ----------------------------------------------------------------------------
// thumb_load_store_address_sequencer: Thumb load/store access generator
// Turns one Thumb load/store request into its ordered memory accesses.
// ----------------------------------------------------------------------------
// An instruction request is taken, then the block issues one result per
// cycle through a registered output stage unless out_ch.ready stalls it:
// single transfers (ldr/str imm, strh imm, ldr pc) and unknown selectors give
// one result; stmia/ldmia give one per register in the list (one for an empty
// list), at most 8. The single shared 32-bit adder forms one address per
// cycle and the list walker retires one register per cycle, both only while
// the output stage is free. in_ch.ready is low while an instruction is in
// flight; a result stalled by out_ch.ready holds the sequencer. A new request
// may be taken while the final result still waits.
// ----------------------------------------------------------------------------
module thumb_load_store_address_sequencer (
  input  logic         clk,
  input  logic         rst_n,
  tlsas_in_if.sink     in_ch,
  tlsas_out_if.source  out_ch
);

  logic                           in_fire;
  logic                           out_free;
  tlsas_pkg::agu_ctl_t            agu_ctl;
  tlsas_pkg::seq_res_t            res;
  logic [tlsas_pkg::WORD_W-1:0]   init_a;
  logic [tlsas_pkg::WORD_W-1:0]   offset;
  logic [tlsas_pkg::WORD_W-1:0]   acc;
  logic [tlsas_pkg::WORD_W-1:0]   sum;
  logic [tlsas_pkg::WORD_W-1:0]   sum_aligned;

  // output stage
  logic                           out_valid_r;
  logic                           access_r;
  logic                           is_write_r;
  logic                           is_half_r;
  logic [tlsas_pkg::WORD_W-1:0]   address_r,  address_nxt;
  logic [tlsas_pkg::REG_W-1:0]    reg_index_r;
  logic                           wb_valid_r;
  logic [tlsas_pkg::REG_W-1:0]    wb_reg_r;
  logic [tlsas_pkg::WORD_W-1:0]   wb_value_r, wb_value_nxt;
  logic                           last_r;
  logic                           unimp_r;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // pc-relative loads start from the word-aligned pc
  assign init_a = (in_ch.func == tlsas_pkg::FN_LDR_PC) ?
                  {in_ch.pc_value[tlsas_pkg::WORD_W-1:2], 2'b00} : in_ch.base_value;
  assign offset = tlsas_pkg::offset_of(in_ch.func, in_ch.instr);

  tlsas_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .func     (in_ch.func),
    .instr    (in_ch.instr),
    .out_free (out_free),
    .in_ready (in_ch.ready),
    .agu_ctl  (agu_ctl),
    .res      (res)
  );

  tlsas_agu u_agu (
    .clk    (clk),
    .ctl    (agu_ctl),
    .init_a (init_a),
    .offset (offset),
    .acc    (acc),
    .sum    (sum)
  );

  // single transfers align to access size; list transfers use the running base
  assign sum_aligned = res.is_half ? {sum[tlsas_pkg::WORD_W-1:1], 1'b0} :
                                     {sum[tlsas_pkg::WORD_W-1:2], 2'b00};

  always_comb begin
    address_nxt = '0;
    if (res.access) begin
      address_nxt = res.addr_sum ? sum_aligned : acc;
    end
  end

  // writeback is the base after the last step (+4, or +0 for an empty list)
  assign wb_value_nxt = res.wb_valid ? sum : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.fire) begin
      access_r    <= res.access;
      is_write_r  <= res.is_write;
      is_half_r   <= res.is_half;
      address_r   <= address_nxt;
      reg_index_r <= res.reg_index;
      wb_valid_r  <= res.wb_valid;
      wb_reg_r    <= res.wb_reg;
      wb_value_r  <= wb_value_nxt;
      last_r      <= res.last;
      unimp_r     <= res.unimp;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.access_valid    = access_r;
  assign out_ch.is_write        = is_write_r;
  assign out_ch.is_halfword     = is_half_r;
  assign out_ch.address         = address_r;
  assign out_ch.reg_index       = reg_index_r;
  assign out_ch.writeback_valid = wb_valid_r;
  assign out_ch.writeback_reg   = wb_reg_r;
  assign out_ch.writeback_value = wb_value_r;
  assign out_ch.last            = last_r;
  assign out_ch.unimplemented   = unimp_r;

endmodule

FILE: rtl/tlsas_chk.sv
// ----------------------------------------------------------------------------
// tlsas_chk: port-level checks
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module tlsas_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           access_valid,
  input logic                           is_write,
  input logic [tlsas_pkg::WORD_W-1:0]   address,
  input logic                           writeback_valid,
  input logic                           last,
  input logic                           unimplemented
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(address))
    else $error("stalled result changed");

  // one instruction in flight at a time
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_unimp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && unimplemented |-> last && !access_valid && !writeback_valid)
    else $error("unsupported form result malformed");

  a_wb_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && writeback_valid |-> last)
    else $error("writeback before final result");

  a_no_access: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !access_valid |-> (address == '0) && !is_write)
    else $error("idle access fields not zero");

endmodule

bind thumb_load_store_address_sequencer tlsas_chk u_tlsas_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .access_valid    (out_ch.access_valid),
  .is_write        (out_ch.is_write),
  .address         (out_ch.address),
  .writeback_valid (out_ch.writeback_valid),
  .last            (out_ch.last),
  .unimplemented   (out_ch.unimplemented)
);
